[sv/wve_pkg.sv]
// Shared widths, constants and types of the windowed velocity estimator.
`timescale 1ns / 1ps
package wve_pkg;

   localparam int OBSTACLES_DEF  = 16;
   localparam int WINDOW_MAX_DEF = 16;

   // field widths
   localparam int ID_W       = 4;
   localparam int VIS_W      = 16;
   localparam int POS_W      = 24;
   localparam int TIME_W     = 48;
   localparam int SPEED_W    = 23;
   localparam int WIN_W      = 5;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MIN_VIS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_WIN_LEN = CSR_IDX_W'(1);

   localparam logic [VIS_W-1:0] MIN_VIS_RST = VIS_W'(5);
   localparam logic [WIN_W-1:0] WIN_LEN_RST = WIN_W'(8);

   // arithmetic widths
   localparam int MICROS    = 1000000;
   localparam int MICROS_W  = 20;
   localparam int DIFF_W    = POS_W + 1;
   localparam int MX_W      = DIFF_W + MICROS_W;
   localparam int SQ_W      = 2 * DIFF_W;
   localparam int RAD_W     = SQ_W + 12;
   localparam int ROOT_W    = RAD_W / 2;
   localparam int PS_W      = ROOT_W + MICROS_W;
   localparam int DVD_W     = 52;
   localparam int DVS_W     = TIME_W + 6;
   localparam int SUM_W     = 52;
   localparam int POS_MAX   = 8388607;
   localparam int SPEED_MAX = 8388607;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic [TIME_W-1:0]       t;
   } wve_sample_type;

   typedef struct packed {
      logic busy;
      logic done;
   } wve_unit_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_META,
      ST_RD_FIRST,
      ST_LOAD_FIRST,
      ST_RD_NEXT,
      ST_CAPTURE,
      ST_SQX,
      ST_SQY,
      ST_SQRT_GO,
      ST_MY,
      ST_SQRT_WAIT,
      ST_SCALE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_NEXT,
      ST_EMIT
   } wve_state_type;

   typedef enum logic [2:0] {
      PH_X,
      PH_Y,
      PH_S,
      PH_AX,
      PH_AY,
      PH_AS
   } wve_phase_type;

endpackage

[sv/wve_if.sv]
// Channel interfaces of the velocity estimator: sample, result and register write.
`timescale 1ns / 1ps
interface wve_req_if import wve_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [ID_W-1:0]         obstacle_id;
   logic signed [VIS_W-1:0] visibility;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic [TIME_W-1:0]       timestamp;
   modport source (output valid, obstacle_id, visibility, pos_x, pos_y, timestamp,
                   input ready);
   modport sink (input valid, obstacle_id, visibility, pos_x, pos_y, timestamp,
                 output ready);
endinterface

interface wve_rsp_if import wve_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [ID_W-1:0]         result_id;
   logic                    cleared;
   logic signed [VIS_W-1:0] result_visibility;
   logic signed [POS_W-1:0] vel_x;
   logic signed [POS_W-1:0] vel_y;
   logic [SPEED_W-1:0]      speed;
   modport source (output valid, result_id, cleared, result_visibility, vel_x, vel_y, speed,
                   input ready);
   modport sink (input valid, result_id, cleared, result_visibility, vel_x, vel_y, speed,
                 output ready);
endinterface

interface wve_csr_if import wve_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[sv/windowed_velocity_estimator_unit.sv]
// A cleared item or a ring of one sample skips the arithmetic; otherwise each interval of the
// n averaged samples with a positive time step takes three divisions and a root, and the
// averages three more, on the shared 52-step divider and the 31-step root. One item at a
// time; the next item is taken while the last result waits in rsp. Reset (synchronous):
// per-obstacle valid bits cleared, so every ring reads empty; min_visibility 5,
// window_length 8; samples kept.
`timescale 1ns / 1ps
module windowed_velocity_estimator_unit import wve_pkg::*; #(
   parameter int OBSTACLES  = OBSTACLES_DEF,
   parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
   input logic   clock,
   input logic   reset,
   wve_req_if.sink   req_ch,
   wve_rsp_if.source rsp_ch,
   wve_csr_if.sink   csr_ch
);

   localparam int OBS_W   = (OBSTACLES > 1) ? $clog2(OBSTACLES) : 1;
   localparam int SLOT_W  = $clog2(WINDOW_MAX);
   localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
   localparam int RING_AW = $clog2(OBSTACLES * WINDOW_MAX);
   localparam int RING_D  = OBSTACLES * WINDOW_MAX;

   wve_state_type state_ff, state_in;
   wve_phase_type phase_ff;

   // configuration
   logic [VIS_W-1:0] min_vis_ff;
   logic [WIN_W-1:0] win_len_ff;

   // item
   logic [ID_W-1:0]  id_ff;
   logic [OBS_W-1:0] idx_ff;
   logic [VIS_W-1:0] vis_ff;
   wve_sample_type   smp_ff;

   // memories
   wve_sample_type   ring_mem [RING_D];
   wve_sample_type   ring_rd_ff;
   logic [SLOT_W-1:0] head_mem [OBSTACLES];
   logic [CNT_W-1:0]  count_mem [OBSTACLES];
   logic [OBSTACLES-1:0] meta_vld_ff;
   logic [SLOT_W-1:0] head_rd_ff;
   logic [CNT_W-1:0]  count_rd_ff;
   logic              vld_rd_ff;

   // walk and arithmetic
   logic [RING_AW-1:0] base_ff;
   logic [SLOT_W-1:0]  ptr_ff;
   logic [CNT_W-1:0]   kleft_ff;
   logic [CNT_W-1:0]   nm1_ff;
   wve_sample_type     prev_ff;
   logic signed [DIFF_W-1:0] dx_ff;
   logic signed [DIFF_W-1:0] dy_ff;
   logic [TIME_W-1:0]  dt_ff;
   logic [SQ_W-1:0]    sq_ff;
   logic [SQ_W-1:0]    d2_ff;
   logic signed [MX_W-1:0] mx_ff;
   logic signed [MX_W-1:0] my_ff;
   logic [PS_W-1:0]    ps_ff;
   logic [SUM_W-1:0]   sx_ff;
   logic [SUM_W-1:0]   sy_ff;
   logic [SUM_W-1:0]   ss_ff;

   // pending result
   logic                    res_cleared_ff;
   logic signed [POS_W-1:0] res_vx_ff;
   logic signed [POS_W-1:0] res_vy_ff;
   logic [SPEED_W-1:0]      res_sp_ff;

   // output register
   logic                    rsp_valid_ff;
   logic [ID_W-1:0]         rsp_id_ff;
   logic                    rsp_cleared_ff;
   logic signed [VIS_W-1:0] rsp_vis_ff;
   logic signed [POS_W-1:0] rsp_vx_ff;
   logic signed [POS_W-1:0] rsp_vy_ff;
   logic [SPEED_W-1:0]      rsp_sp_ff;

   // control strobes
   logic req_accept;
   logic in_range;
   logic ring_rd_en;
   logic ring_we;
   logic meta_we;
   logic div_start;
   logic sqrt_start;
   logic rsp_load;

   // combinational values
   logic [SLOT_W-1:0]  head_cur, head_new, start_c;
   logic [CNT_W-1:0]   cnt_cur, cnt_new, win_c, n_c;
   logic [SLOT_W-1:0]  meta_head_wr;
   logic [CNT_W-1:0]   meta_cnt_wr;
   logic [7:0]         win_ext, start_sum;
   logic               below;
   logic [RING_AW-1:0] base_c;
   logic [RING_AW-1:0] ring_rd_addr;
   logic [SLOT_W-1:0]  ptr_next;
   logic signed [SQ_W-1:0] sq_full;
   logic [MX_W-1:0]    mx_mag, my_mag;
   logic [SUM_W-1:0]   sx_mag, sy_mag;
   logic [DVD_W-1:0]   div_dividend;
   logic [DVS_W-1:0]   div_divisor;
   logic [DVD_W-1:0]   div_q;
   logic [SUM_W-1:0]   q_sum;
   logic [ROOT_W-1:0]  sqrt_root;
   wve_unit_status_type div_st, sqrt_st;

   // saturate a sign and magnitude to the velocity range
   function automatic logic signed [POS_W-1:0] sat_vel(input logic neg,
                                                       input logic [DVD_W-1:0] mag);
      if (!neg && mag > DVD_W'(POS_MAX))
         return POS_W'(POS_MAX);
      else if (neg && mag > DVD_W'(POS_MAX) + 1'b1)
         return POS_W'(POS_MAX) + 1'b1;
      else if (neg)
         return -$signed(POS_W'(mag));
      else
         return $signed(POS_W'(mag));
   endfunction

   assign req_accept = req_ch.valid && req_ch.ready;
   assign in_range   = 9'(req_ch.obstacle_id) < 9'(OBSTACLES);

   // register writes
   assign csr_ch.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         min_vis_ff <= MIN_VIS_RST;
         win_len_ff <= WIN_LEN_RST;
      end else if (csr_ch.valid) begin
         if (csr_ch.index == REG_MIN_VIS)
            min_vis_ff <= csr_ch.data[VIS_W-1:0];
         else if (csr_ch.index == REG_WIN_LEN)
            win_len_ff <= csr_ch.data[WIN_W-1:0];
      end
   end

   // ring bookkeeping for the new sample
   always_comb begin
      head_cur  = vld_rd_ff ? head_rd_ff : '0;
      cnt_cur   = vld_rd_ff ? count_rd_ff : '0;
      below     = $signed(vis_ff) < $signed(min_vis_ff);
      head_new  = (head_cur == SLOT_W'(WINDOW_MAX - 1)) ? '0 : head_cur + 1'b1;
      cnt_new   = (cnt_cur < CNT_W'(WINDOW_MAX)) ? cnt_cur + 1'b1 : cnt_cur;
      win_ext   = 8'(win_len_ff);
      if (win_ext == 8'd0)
         win_ext = 8'd1;
      else if (win_ext > 8'(WINDOW_MAX))
         win_ext = 8'(WINDOW_MAX);
      win_c     = CNT_W'(win_ext);
      n_c       = (cnt_new < win_c) ? cnt_new : win_c;
      start_sum = 8'(head_new) + 8'(WINDOW_MAX) - 8'(n_c);
      if (start_sum >= 8'(WINDOW_MAX))
         start_sum = start_sum - 8'(WINDOW_MAX);
      start_c      = SLOT_W'(start_sum);
      meta_head_wr = below ? '0 : head_new;
      meta_cnt_wr  = below ? '0 : cnt_new;
      base_c       = RING_AW'(idx_ff) * RING_AW'(WINDOW_MAX);
   end

   assign ring_rd_addr = base_ff + RING_AW'(ptr_ff);
   assign ptr_next     = (ptr_ff == SLOT_W'(WINDOW_MAX - 1)) ? '0 : ptr_ff + 1'b1;

   // per-obstacle head and count
   always_ff @(posedge clock) begin
      if (meta_we) begin
         head_mem[idx_ff]  <= meta_head_wr;
         count_mem[idx_ff] <= meta_cnt_wr;
      end
      if (req_accept) begin
         head_rd_ff  <= head_mem[OBS_W'(req_ch.obstacle_id)];
         count_rd_ff <= count_mem[OBS_W'(req_ch.obstacle_id)];
         vld_rd_ff   <= meta_vld_ff[OBS_W'(req_ch.obstacle_id)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         meta_vld_ff <= '0;
      else if (meta_we)
         meta_vld_ff[idx_ff] <= 1'b1;
   end

   // sample ring
   always_ff @(posedge clock) begin
      if (ring_we)
         ring_mem[base_c + RING_AW'(head_cur)] <= smp_ff;
      if (ring_rd_en)
         ring_rd_ff <= ring_mem[ring_rd_addr];
   end

   // divider operands by phase
   always_comb begin
      mx_mag = mx_ff[MX_W-1] ? MX_W'(-mx_ff) : MX_W'(mx_ff);
      my_mag = my_ff[MX_W-1] ? MX_W'(-my_ff) : MX_W'(my_ff);
      sx_mag = sx_ff[SUM_W-1] ? -sx_ff : sx_ff;
      sy_mag = sy_ff[SUM_W-1] ? -sy_ff : sy_ff;
      unique case (phase_ff)
         PH_X: begin
            div_dividend = DVD_W'(mx_mag);
            div_divisor  = DVS_W'(dt_ff);
         end
         PH_Y: begin
            div_dividend = DVD_W'(my_mag);
            div_divisor  = DVS_W'(dt_ff);
         end
         PH_S: begin
            div_dividend = DVD_W'(ps_ff);
            div_divisor  = {dt_ff, 6'b000000};
         end
         PH_AX: begin
            div_dividend = DVD_W'(sx_mag);
            div_divisor  = DVS_W'(nm1_ff);
         end
         PH_AY: begin
            div_dividend = DVD_W'(sy_mag);
            div_divisor  = DVS_W'(nm1_ff);
         end
         PH_AS: begin
            div_dividend = DVD_W'(ss_ff);
            div_divisor  = DVS_W'(nm1_ff);
         end
         default: begin
            div_dividend = '0;
            div_divisor  = DVS_W'(1);
         end
      endcase
   end

   wve_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_q),
      .status   (div_st)
   );

   wve_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ({d2_ff, 12'h000}),
      .root     (sqrt_root),
      .status   (sqrt_st)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (req_accept && in_range) state_in = ST_META;
         ST_META: begin
            if (below)
               state_in = (cnt_cur == '0) ? ST_IDLE : ST_EMIT;
            else
               state_in = (n_c > CNT_W'(1)) ? ST_RD_FIRST : ST_EMIT;
         end
         ST_RD_FIRST:   state_in = ST_LOAD_FIRST;
         ST_LOAD_FIRST: state_in = ST_CAPTURE;
         ST_RD_NEXT:    state_in = ST_CAPTURE;
         ST_CAPTURE:    state_in = (ring_rd_ff.t > prev_ff.t) ? ST_SQX : ST_NEXT;
         ST_SQX:        state_in = ST_SQY;
         ST_SQY:        state_in = ST_SQRT_GO;
         ST_SQRT_GO:    state_in = ST_MY;
         ST_MY:         state_in = ST_SQRT_WAIT;
         ST_SQRT_WAIT:  if (!sqrt_st.busy) state_in = ST_SCALE;
         ST_SCALE:      state_in = ST_DIV_START;
         ST_DIV_START:  state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_st.done) begin
               if (phase_ff == PH_S)
                  state_in = ST_NEXT;
               else if (phase_ff == PH_AS)
                  state_in = ST_EMIT;
               else
                  state_in = ST_DIV_START;
            end
         end
         ST_NEXT:       state_in = (kleft_ff == CNT_W'(1)) ? ST_DIV_START : ST_RD_NEXT;
         ST_EMIT:       if (!rsp_valid_ff || rsp_ch.ready) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ch.ready = (state_ff == ST_IDLE);
      ring_rd_en   = (state_ff == ST_RD_FIRST) || (state_ff == ST_LOAD_FIRST) ||
                     (state_ff == ST_RD_NEXT);
      meta_we      = (state_ff == ST_META);
      ring_we      = (state_ff == ST_META) && !below;
      sqrt_start   = (state_ff == ST_SQRT_GO);
      div_start    = (state_ff == ST_DIV_START);
      rsp_load     = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   assign sq_full = dx_ff * dx_ff;
   assign q_sum   = SUM_W'(div_q);

   // datapath: latch, walk the ring, accumulate and average
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               id_ff    <= req_ch.obstacle_id;
               idx_ff   <= OBS_W'(req_ch.obstacle_id);
               vis_ff   <= req_ch.visibility;
               smp_ff.x <= req_ch.pos_x;
               smp_ff.y <= req_ch.pos_y;
               smp_ff.t <= req_ch.timestamp;
            end
         end
         ST_META: begin
            base_ff        <= base_c;
            ptr_ff         <= start_c;
            kleft_ff       <= n_c - 1'b1;
            nm1_ff         <= n_c - 1'b1;
            sx_ff          <= '0;
            sy_ff          <= '0;
            ss_ff          <= '0;
            res_cleared_ff <= below;
            res_vx_ff      <= '0;
            res_vy_ff      <= '0;
            res_sp_ff      <= '0;
         end
         ST_RD_FIRST, ST_RD_NEXT: ptr_ff <= ptr_next;
         ST_LOAD_FIRST: begin
            prev_ff <= ring_rd_ff;
            ptr_ff  <= ptr_next;
         end
         ST_CAPTURE: begin
            dx_ff   <= DIFF_W'(ring_rd_ff.x) - DIFF_W'(prev_ff.x);
            dy_ff   <= DIFF_W'(ring_rd_ff.y) - DIFF_W'(prev_ff.y);
            dt_ff   <= ring_rd_ff.t - prev_ff.t;
            prev_ff <= ring_rd_ff;
         end
         ST_SQX:     sq_ff <= SQ_W'(sq_full);
         ST_SQY:     d2_ff <= sq_ff + SQ_W'(dy_ff * dy_ff);
         ST_SQRT_GO: mx_ff <= MX_W'(dx_ff * $signed({1'b0, MICROS_W'(MICROS)}));
         ST_MY:      my_ff <= MX_W'(dy_ff * $signed({1'b0, MICROS_W'(MICROS)}));
         ST_SCALE: begin
            ps_ff    <= PS_W'(sqrt_root) * PS_W'(MICROS);
            phase_ff <= PH_X;
         end
         ST_DIV_WAIT: begin
            if (div_st.done) begin
               unique case (phase_ff)
                  PH_X: begin
                     sx_ff    <= sx_ff + (mx_ff[MX_W-1] ? -q_sum : q_sum);
                     phase_ff <= PH_Y;
                  end
                  PH_Y: begin
                     sy_ff    <= sy_ff + (my_ff[MX_W-1] ? -q_sum : q_sum);
                     phase_ff <= PH_S;
                  end
                  PH_S:  ss_ff <= ss_ff + q_sum;
                  PH_AX: begin
                     res_vx_ff <= sat_vel(sx_ff[SUM_W-1], div_q);
                     phase_ff  <= PH_AY;
                  end
                  PH_AY: begin
                     res_vy_ff <= sat_vel(sy_ff[SUM_W-1], div_q);
                     phase_ff  <= PH_AS;
                  end
                  PH_AS: begin
                     res_sp_ff <= (div_q > DVD_W'(SPEED_MAX)) ? SPEED_W'(SPEED_MAX)
                                                              : div_q[SPEED_W-1:0];
                  end
                  default: phase_ff <= PH_X;
               endcase
            end
         end
         ST_NEXT: begin
            kleft_ff <= kleft_ff - 1'b1;
            if (kleft_ff == CNT_W'(1))
               phase_ff <= PH_AX;
         end
         default: ;
      endcase
   end

   // hold the result until taken
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (rsp_load)
         rsp_valid_ff <= 1'b1;
      else if (rsp_ch.ready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_id_ff      <= id_ff;
         rsp_cleared_ff <= res_cleared_ff;
         rsp_vis_ff     <= vis_ff;
         rsp_vx_ff      <= res_vx_ff;
         rsp_vy_ff      <= res_vy_ff;
         rsp_sp_ff      <= res_sp_ff;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.result_id         = rsp_id_ff;
   assign rsp_ch.cleared           = rsp_cleared_ff;
   assign rsp_ch.result_visibility = rsp_vis_ff;
   assign rsp_ch.vel_x             = rsp_vx_ff;
   assign rsp_ch.vel_y             = rsp_vy_ff;
   assign rsp_ch.speed             = rsp_sp_ff;

   // checks
   a_interval_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CAPTURE) |-> (kleft_ff != '0))
      else $error("interval walk ran past the window");

   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_st.busy)
      else $error("divider started while busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      ring_we |-> (meta_cnt_wr != '0 && meta_cnt_wr <= CNT_W'(WINDOW_MAX)))
      else $error("ring count out of range");

   a_sqrt_done_wait: assert property (@(posedge clock) disable iff (reset)
      sqrt_st.done |-> (state_ff == ST_SQRT_WAIT))
      else $error("square root finished outside its wait");

endmodule

[sv/wve_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module wve_div import wve_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DVD_W-1:0]    dividend,
   input  logic [DVS_W-1:0]    divisor,
   output logic [DVD_W-1:0]    quotient,
   output wve_unit_status_type status
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff;
   logic [DVS_W-1:0] rem_ff;
   logic [DVS_W-1:0] dvs_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DVS_W:0]   rem_sh;
   logic [DVS_W:0]   rem_sub;
   logic             fits;

   // shift in the next dividend bit and try the subtract
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DVD_W-1]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      fits    = rem_sh >= {1'b0, dvs_ff};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DVD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DVD_W-2:0], fits};
         rem_ff <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

[sv/wve_isqrt.sv]
// Floor square root, one root bit per cycle.
`timescale 1ns / 1ps
module wve_isqrt import wve_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [RAD_W-1:0]    radicand,
   output logic [ROOT_W-1:0]   root,
   output wve_unit_status_type status
);

   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic [RAD_W-1:0]  rad_ff;
   logic [ROOT_W+1:0] rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [ROOT_W+2:0] rem_sh;
   logic [ROOT_W+2:0] trial;
   logic [ROOT_W+2:0] rem_sub;
   logic              fits;

   // bring down two bits and test root*4+1
   always_comb begin
      rem_sh  = {rem_ff[ROOT_W:0], rad_ff[RAD_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      rem_sub = rem_sh - trial;
      fits    = rem_sh >= trial;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(ROOT_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         rem_ff  <= fits ? rem_sub[ROOT_W+1:0] : rem_sh[ROOT_W+1:0];
         root_ff <= {root_ff[ROOT_W-2:0], fits};
      end
   end

   assign root        = root_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

[dv/windowed_velocity_estimator_unit_tb.sv]
// Self-checking testbench of the windowed velocity estimator: directed and random samples.
`timescale 1ns / 1ps
module windowed_velocity_estimator_unit_tb;
   import wve_pkg::*;

   localparam int NUM_OBS = OBSTACLES_DEF;
   localparam int WIN_MAX = WINDOW_MAX_DEF;

   typedef struct {
      logic [ID_W-1:0]         id;
      logic                    cleared;
      logic signed [VIS_W-1:0] vis;
      logic signed [POS_W-1:0] vx;
      logic signed [POS_W-1:0] vy;
      logic [SPEED_W-1:0]      spd;
   } velocity_result_type;

   logic clock;
   logic reset;

   wve_req_if req_ch ();
   wve_rsp_if rsp_ch ();
   wve_csr_if csr_ch ();

   windowed_velocity_estimator_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predictor copy of the block state and registers
   logic signed [VIS_W-1:0] min_vis_q;
   logic [WIN_W-1:0]        win_len_q;
   longint                  ring_x_q [NUM_OBS][WIN_MAX];
   longint                  ring_y_q [NUM_OBS][WIN_MAX];
   longint                  ring_t_q [NUM_OBS][WIN_MAX];
   int                      head_q [NUM_OBS];
   int                      count_q [NUM_OBS];

   velocity_result_type     pending_velocities [$];
   int                      error_count;
   int                      samples_sent;
   int                      results_seen;
   int                      clears_seen;
   int                      rsp_wait;
   bit                      rsp_no_stall;
   bit                      req_no_gap;

   // per-obstacle stimulus history for well-formed tracks
   longint                  last_t [NUM_OBS];
   int                      last_x [NUM_OBS];
   int                      last_y [NUM_OBS];

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   initial begin
      #200ms;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned bit_q;
      root  = 0;
      bit_q = 64'd1 << 62;
      while (bit_q > v) bit_q >>= 2;
      while (bit_q != 0) begin
         if (v >= root + bit_q) begin
            v    -= root + bit_q;
            root  = (root >> 1) + bit_q;
         end else begin
            root >>= 1;
         end
         bit_q >>= 2;
      end
      return root;
   endfunction

   function automatic longint clamp_pos(longint v);
      if (v > POS_MAX) return longint'(POS_MAX);
      if (v < -POS_MAX - 1) return longint'(-POS_MAX - 1);
      return v;
   endfunction

   // update the predicted rings and compute the velocity result of one sample
   function automatic bit estimate_velocity(input logic [ID_W-1:0] id,
                                            input logic signed [VIS_W-1:0] vis,
                                            input logic signed [POS_W-1:0] px,
                                            input logic signed [POS_W-1:0] py,
                                            input logic [TIME_W-1:0] ts,
                                            output velocity_result_type res);
      int     h, win, n, start, a, b;
      longint dt, dx, dy, sx, sy, ss;
      longint unsigned d2, root;
      res.id = id; res.vis = vis; res.cleared = 1'b0;
      res.vx = '0; res.vy = '0; res.spd = '0;
      if (vis < min_vis_q) begin
         if (count_q[id] == 0) return 1'b0;
         count_q[id] = 0;
         head_q[id]  = 0;
         res.cleared = 1'b1;
         return 1'b1;
      end
      h = head_q[id];
      ring_x_q[id][h] = longint'(px);
      ring_y_q[id][h] = longint'(py);
      ring_t_q[id][h] = longint'(ts);
      head_q[id] = (h + 1 == WIN_MAX) ? 0 : h + 1;
      if (count_q[id] < WIN_MAX) count_q[id]++;
      win = int'(win_len_q);
      if (win == 0) win = 1;
      if (win > WIN_MAX) win = WIN_MAX;
      n = (count_q[id] < win) ? count_q[id] : win;
      start = (head_q[id] + WIN_MAX - n) % WIN_MAX;
      sx = 0; sy = 0; ss = 0;
      for (int k = 1; k < n; k++) begin
         a  = (start + k - 1) % WIN_MAX;
         b  = (start + k) % WIN_MAX;
         dt = ring_t_q[id][b] - ring_t_q[id][a];
         dx = ring_x_q[id][b] - ring_x_q[id][a];
         dy = ring_y_q[id][b] - ring_y_q[id][a];
         if (dt > 0) begin
            d2   = longint'(dx * dx) + longint'(dy * dy);
            root = floor_sqrt(d2 << 12);
            sx  += dx * 1000000 / dt;
            sy  += dy * 1000000 / dt;
            ss  += longint'((root * 64'd1000000) / (longint'(dt) << 6));
         end
      end
      if (n > 1) begin
         res.vx = POS_W'(clamp_pos(sx / (n - 1)));
         res.vy = POS_W'(clamp_pos(sy / (n - 1)));
         ss = ss / (n - 1);
         if (ss > SPEED_MAX) ss = longint'(SPEED_MAX);
         res.spd = SPEED_W'(ss);
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      error_count++;
      $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
   endtask

   // check each result item against the oldest expectation
   always @(posedge clock) begin
      velocity_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         rsp_wait = rsp_no_stall ? 0 : $urandom_range(0, 10);
         if (pending_velocities.size() == 0) begin
            report_mismatch("unexpected result_id", longint'(rsp_ch.result_id), -64'sd1);
         end else begin
            want = pending_velocities.pop_front();
            if (want.cleared) clears_seen++;
            if (rsp_ch.result_id !== want.id)
               report_mismatch("result_id", longint'(rsp_ch.result_id), longint'(want.id));
            if (rsp_ch.cleared !== want.cleared)
               report_mismatch("cleared", longint'(rsp_ch.cleared), longint'(want.cleared));
            if (rsp_ch.result_visibility !== want.vis)
               report_mismatch("visibility", longint'(rsp_ch.result_visibility),
                               longint'(want.vis));
            if (rsp_ch.vel_x !== want.vx)
               report_mismatch("vel_x", longint'(rsp_ch.vel_x), longint'(want.vx));
            if (rsp_ch.vel_y !== want.vy)
               report_mismatch("vel_y", longint'(rsp_ch.vel_y), longint'(want.vy));
            if (rsp_ch.speed !== want.spd)
               report_mismatch("speed", longint'(rsp_ch.speed), longint'(want.spd));
         end
      end
   end

   // stall the result side
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready = 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_ch.ready = 1'b0;
         rsp_wait--;
      end else begin
         rsp_ch.ready = 1'b1;
      end
   end

   // send one sample item and record its expected result
   task automatic send_sample(logic [ID_W-1:0] id, logic signed [VIS_W-1:0] vis,
                              logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
                              logic [TIME_W-1:0] ts);
      int gap;
      velocity_result_type res;
      gap = req_no_gap ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       = 1'b1;
      req_ch.obstacle_id = id;
      req_ch.visibility  = vis;
      req_ch.pos_x       = px;
      req_ch.pos_y       = py;
      req_ch.timestamp   = ts;
      do @(posedge clock); while (!req_ch.ready);
      if (estimate_velocity(id, vis, px, py, ts, res))
         pending_velocities = {pending_velocities, res};
      samples_sent++;
      last_t[id] = longint'(ts);
      last_x[id] = int'(px);
      last_y[id] = int'(py);
      @(negedge clock);
   endtask

   // drain every result and let a no-result item settle
   task automatic wait_idle();
      req_ch.valid = 1'b0;
      while (pending_velocities.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      wait_idle();
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = value;
      do @(posedge clock); while (!csr_ch.ready);
      if (idx == REG_MIN_VIS) min_vis_q = value;
      else if (idx == REG_WIN_LEN) win_len_q = value[WIN_W-1:0];
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // single sample, normal track, zero and negative time steps, clearing
   task automatic test_directed_track();
      send_sample(4'd0, 16'sd4, 24'sd0, 24'sd0, 48'd0);
      send_sample(4'd0, 16'sd5, 24'sd0, 24'sd0, 48'd1000);
      send_sample(4'd0, 16'sd6, 24'sd1024, -24'sd2048, 48'd101000);
      send_sample(4'd0, 16'sd7, 24'sd3000, 24'sd500, 48'd101000);
      send_sample(4'd0, 16'sd8, 24'sd3100, 24'sd600, 48'd50000);
      send_sample(4'd0, 16'sd32767, 24'sd3200, 24'sd700, 48'd250000);
      send_sample(4'd0, -16'sd32768, 24'sd0, 24'sd0, 48'd0);
      send_sample(4'd0, 16'sd0, 24'sd0, 24'sd0, 48'd0);
      // extreme positions and timestamps, saturating velocities
      send_sample(4'd15, 16'sd9, -24'sd8388608, -24'sd8388608, 48'hFFFF_FFFF_FFF0);
      send_sample(4'd15, 16'sd9, 24'sd8388607, 24'sd8388607, 48'hFFFF_FFFF_FFF1);
      send_sample(4'd15, 16'sd9, -24'sd8388608, 24'sd8388607, 48'hFFFF_FFFF_FFF2);
      send_sample(4'd15, 16'sd9, 24'sd0, 24'sd0, 48'd5);
      send_sample(4'd15, 16'sd9, 24'sd1, -24'sd1, 48'd281474976710655 - 48'd1);
   endtask

   task automatic test_threshold_extremes();
      write_reg(REG_MIN_VIS, 16'h8000);
      send_sample(4'd3, -16'sd32768, 24'sd10, 24'sd10, 48'd10);
      send_sample(4'd3, -16'sd32768, 24'sd5000, 24'sd10, 48'd20);
      write_reg(REG_MIN_VIS, 16'h7FFF);
      send_sample(4'd3, 16'sd32766, 24'sd0, 24'sd0, 48'd30);
      send_sample(4'd3, 16'sd32767, 24'sd0, 24'sd0, 48'd40);
      send_sample(4'd3, 16'sd32767, 24'sd100, 24'sd0, 48'd60);
      write_reg(REG_MIN_VIS, 16'd5);
   endtask

   task automatic test_window_range();
      longint t;
      t = 64'd1000;
      write_reg(REG_WIN_LEN, 16'd0);
      for (int i = 0; i < 3; i++)
         send_sample(4'd7, 16'sd10, 24'(i * 300), 24'sd0, TIME_W'(t + i * 1000));
      write_reg(REG_WIN_LEN, 16'd1);
      send_sample(4'd7, 16'sd10, 24'sd2000, 24'sd7, TIME_W'(t + 5000));
      write_reg(REG_WIN_LEN, 16'd31);
      for (int i = 0; i < 17; i++)
         send_sample(4'd7, 16'sd10, 24'(i * i * 40), -24'(i * 70),
                     TIME_W'(t + 10000 + i * 997));
      // shrink the window while the ring stays full
      write_reg(REG_WIN_LEN, 16'd16);
      send_sample(4'd7, 16'sd10, 24'sd0, 24'sd0, TIME_W'(t + 40000));
      write_reg(REG_WIN_LEN, 16'd3);
      send_sample(4'd7, 16'sd10, 24'sd50, 24'sd50, TIME_W'(t + 41000));
   endtask

   task automatic random_sample(bit noise_only);
      int mode, id, thr, dx, dy;
      logic signed [VIS_W-1:0] vis;
      logic [TIME_W-1:0] ts;
      mode = noise_only ? 99 : $urandom_range(0, 99);
      id   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
      thr  = int'(min_vis_q);
      if (mode < 82 || thr == -32768) begin
         vis = VIS_W'(thr + int'($urandom_range(0, 32767 - thr)));
         ts  = TIME_W'(last_t[id] + $urandom_range(1, 300000));
         if ($urandom_range(0, 19) == 0) ts = TIME_W'(last_t[id]);
         dx = $urandom_range(0, 1) ? $urandom_range(0, 8000) : -int'($urandom_range(0, 8000));
         dy = $urandom_range(0, 1) ? $urandom_range(0, 8000) : -int'($urandom_range(0, 8000));
         if ($urandom_range(0, 29) == 0) begin
            dx = dx * 1000;
            ts = TIME_W'(last_t[id] + $urandom_range(1, 3));
         end
         send_sample(ID_W'(id), vis, POS_W'(last_x[id] + dx), POS_W'(last_y[id] + dy), ts);
      end else if (mode < 90) begin
         vis = VIS_W'(-32768 + int'($urandom_range(0, thr + 32767)));
         send_sample(ID_W'(id), vis, POS_W'($urandom), POS_W'($urandom),
                     TIME_W'(last_t[id]));
      end else begin
         ts = TIME_W'({$urandom, $urandom});
         send_sample(ID_W'(id), VIS_W'($urandom), POS_W'($urandom), POS_W'($urandom), ts);
      end
   endtask

   // random phases over several settings, mostly short windows
   task automatic test_random_tracks();
      int windows [8] = '{2, 3, 4, 2, 5, 1, 3, 16};
      int counts [8]  = '{300, 260, 220, 250, 180, 150, 240, 60};
      for (int p = 0; p < 8; p++) begin
         write_reg(REG_WIN_LEN, 16'(windows[p]));
         write_reg(REG_MIN_VIS, (p % 3 == 0) ? 16'($urandom_range(0, 20))
                                             : 16'($urandom_range(0, 65535)));
         req_no_gap   = (p == 2);
         rsp_no_stall = (p == 2) || (p == 5);
         for (int i = 0; i < counts[p]; i++) begin
            random_sample(1'b0);
            // let the result side catch up completely once
            if (p == 4 && i == 90) wait_idle();
         end
      end
      req_no_gap   = 1'b0;
      rsp_no_stall = 1'b0;
      for (int i = 0; i < 20; i++) random_sample(1'b1);
   endtask

   initial begin
      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.obstacle_id = '0;
      req_ch.visibility  = '0;
      req_ch.pos_x       = '0;
      req_ch.pos_y       = '0;
      req_ch.timestamp   = '0;
      csr_ch.valid  = 1'b0;
      csr_ch.index  = '0;
      csr_ch.data   = '0;
      rsp_wait      = 0;
      rsp_no_stall  = 1'b0;
      req_no_gap    = 1'b0;
      error_count   = 0;
      samples_sent  = 0;
      results_seen  = 0;
      clears_seen   = 0;
      min_vis_q     = MIN_VIS_RST;
      win_len_q     = WIN_LEN_RST;
      for (int i = 0; i < NUM_OBS; i++) begin
         head_q[i] = 0; count_q[i] = 0;
         last_t[i] = 0; last_x[i] = 0; last_y[i] = 0;
      end
      repeat (7) @(negedge clock);
      reset = 1'b0;

      test_directed_track();
      test_threshold_extremes();
      test_window_range();
      test_random_tracks();

      wait_idle();
      repeat (200) @(negedge clock);
      $display("Covered %0d samples, %0d results (%0d cleared tracks)",
               samples_sent, results_seen, clears_seen);
      $display("Windows 0 to 31 and thresholds at both extremes exercised");
      if (error_count == 0 && pending_velocities.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/wve_pkg.sv
sv/wve_if.sv
sv/wve_div.sv
sv/wve_isqrt.sv
sv/windowed_velocity_estimator_unit.sv
dv/windowed_velocity_estimator_unit_tb.sv
